// File: design/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the least-connection selector: request and
// result payloads, operation codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam int SRV_BITS   = 4;
  localparam int OUT_CNT_BITS = 16;
  localparam int CFG_BITS   = 5;
  localparam logic [CFG_BITS-1:0] SERVERS_RESET = 5'd16;

  // register word index taken from paddr[2]
  localparam logic REG_SERVERS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    KIND_PICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_PICK = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SRV_BITS-1:0] server;
  } in_t;

  typedef struct packed {
    logic [SRV_BITS-1:0]     chosen_server;
    logic [OUT_CNT_BITS-1:0] server_count;
  } out_t;

  // control part of the token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                done;
    op_t                 op;
    logic [SRV_BITS-1:0] target;
    logic [CFG_BITS-1:0] last;
    logic [SRV_BITS-1:0] best_idx;
  } tok_ctl_t;

endpackage

// File: design/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell
// One server slot: holds its open-connection count, updates it when the token
// names it, folds it into a running minimum for picks and hands the token on.
// ----------------------------------------------------------------------------
module lcs_cell import lcs_pkg::*; #(
  parameter int IDX        = 0,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tok_ctl_t              ctl_in,
  input  logic [COUNT_BITS-1:0] count_in,
  output tok_ctl_t              ctl_out,
  output logic [COUNT_BITS-1:0] count_out
);

  localparam bit FIRST     = (IDX == 0);
  localparam bit MATCHABLE = (IDX < (1 << SRV_BITS));
  localparam bit REACHABLE = (IDX < (1 << CFG_BITS));
  localparam logic [SRV_BITS-1:0] MY_IDX = SRV_BITS'(IDX);
  localparam logic [CFG_BITS-1:0] MY_POS = CFG_BITS'(IDX);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [COUNT_BITS-1:0] best_next;
  tok_ctl_t              ctl_next;
  logic                  live;
  logic                  hit;

  always_comb begin
    live      = ctl_in.valid && !ctl_in.done;
    hit       = MATCHABLE && (ctl_in.target == MY_IDX);
    cnt_next  = cnt;
    best_next = count_in;
    ctl_next  = ctl_in;
    ctl_next.valid = live;
    ctl_next.done  = live && REACHABLE && (ctl_in.last == MY_POS);
    if (live) begin
      case (ctl_in.op)
        OP_PICK: begin
          if (FIRST || (cnt < count_in)) begin
            best_next         = cnt;
            ctl_next.best_idx = MY_IDX;
          end
        end
        OP_INC: begin
          if (hit) begin
            if (cnt != CNT_MAX) begin
              cnt_next = cnt + 1'b1;
            end
            best_next = cnt_next;
          end
        end
        OP_DEC: begin
          if (hit) begin
            if (cnt != '0) begin
              cnt_next = cnt - 1'b1;
            end
            best_next = cnt_next;
          end
        end
        default: begin
          if (hit) begin
            best_next = cnt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      ctl_out.valid <= 1'b0;
      ctl_out.done  <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      ctl_out <= ctl_next;
    end
    count_out <= best_next;
  end

endmodule

// File: design/least_connection_selector.sv
// ----------------------------------------------------------------------------
// least_connection_selector
// Least-connections server selector built as a row of per-server cells that
// a request token walks through, one cell per cycle.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_data  (kind, server)
//   out       output     out_valid / out_ready  out_data (chosen_server, count)
//   cfg       input      APB psel/penable       servers_in_use at byte 0
//
// a pick walks cells 0 to n-1, a start or finish walks cells 0 to its server,
// so a request moves through its cells in the chain and then two result registers
// in_ready drops while a token is in the chain or a result waits to move
// into the output register; a new request is taken while out_valid stalls
// reset clears all counts and sets servers_in_use to 16
// ----------------------------------------------------------------------------
module least_connection_selector import lcs_pkg::*; #(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  localparam int SRV_SLOTS = 1 << CFG_BITS;
  localparam int TAPS = (MAX_SERVERS < SRV_SLOTS) ? MAX_SERVERS : SRV_SLOTS;

  logic [CFG_BITS-1:0]   servers_in_use;
  logic [CFG_BITS-1:0]   n_eff;
  logic                  in_flight;
  logic                  held_valid;
  out_t                  held_data;
  logic                  accept;
  logic                  move;
  logic                  done_hit;
  logic [TAPS-1:0]       done_vec;
  out_t                  done_data;
  tok_ctl_t              inj_ctl;
  logic [COUNT_BITS-1:0] inj_count;
  tok_ctl_t              ctl_o [MAX_SERVERS];
  logic [COUNT_BITS-1:0] cnt_o [MAX_SERVERS];
  logic [31:0]           wide_cnt;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_SERVERS_IN_USE) ? PDATA_BITS'(servers_in_use) : '0;
  assign in_ready = !rst && !in_flight && !held_valid;
  assign accept   = in_valid && in_ready;
  assign move     = held_valid && (!out_valid || out_ready);

  always_comb begin
    if (servers_in_use == '0) begin
      n_eff = CFG_BITS'(1);
    end else if (int'(servers_in_use) > MAX_SERVERS) begin
      n_eff = CFG_BITS'(MAX_SERVERS);
    end else begin
      n_eff = servers_in_use;
    end
  end

  // token built from the request
  always_comb begin
    inj_ctl          = '0;
    inj_ctl.valid    = accept;
    inj_ctl.target   = in_data.server;
    inj_ctl.best_idx = in_data.server;
    inj_count        = '0;
    case (kind_t'(in_data.kind))
      KIND_START, KIND_FINISH: begin
        if ({1'b0, in_data.server} < n_eff) begin
          inj_ctl.op = (kind_t'(in_data.kind) == KIND_START) ? OP_INC : OP_DEC;
        end else begin
          inj_ctl.op = OP_READ;
        end
        if (int'(in_data.server) < MAX_SERVERS) begin
          inj_ctl.last = {1'b0, in_data.server};
        end else begin
          inj_ctl.last = CFG_BITS'(MAX_SERVERS - 1);
        end
      end
      default: begin
        inj_ctl.op       = OP_PICK;
        inj_ctl.best_idx = '0;
        inj_ctl.last     = n_eff - 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    if (i == 0) begin : g_head
      lcs_cell #(.IDX(i), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl_in    (inj_ctl),
        .count_in  (inj_count),
        .ctl_out   (ctl_o[i]),
        .count_out (cnt_o[i])
      );
    end else begin : g_body
      lcs_cell #(.IDX(i), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl_in    (ctl_o[i-1]),
        .count_in  (cnt_o[i-1]),
        .ctl_out   (ctl_o[i]),
        .count_out (cnt_o[i])
      );
    end
  end

  // finished token can only sit in cells 0 to TAPS-1
  always_comb begin
    done_data = '0;
    wide_cnt  = '0;
    for (int i = 0; i < TAPS; i++) begin
      done_vec[i] = ctl_o[i].valid && ctl_o[i].done;
      if (done_vec[i]) begin
        wide_cnt                = wide_cnt | 32'(cnt_o[i]);
        done_data.chosen_server = done_data.chosen_server | ctl_o[i].best_idx;
      end
    end
    done_data.server_count = wide_cnt[OUT_CNT_BITS-1:0];
    done_hit = |done_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= SERVERS_RESET;
      in_flight      <= 1'b0;
      held_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_SERVERS_IN_USE)) begin
        servers_in_use <= pwdata[CFG_BITS-1:0];
      end
      if (accept) begin
        in_flight <= 1'b1;
      end else if (done_hit) begin
        in_flight <= 1'b0;
      end
      if (done_hit) begin
        held_valid <= 1'b1;
      end else if (move) begin
        held_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (done_hit) begin
      held_data <= done_data;
    end
    if (move) begin
      out_data <= held_data;
    end
  end

`ifndef ASSERT_OFF
  a_single_owner: assert property (@(posedge clk) disable iff (rst)
    in_flight |-> !held_valid)
    else $error("token in chain while a result is held");

  a_done_in_flight: assert property (@(posedge clk) disable iff (rst)
    done_hit |-> in_flight)
    else $error("result appeared with no request in the chain");

  a_one_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec))
    else $error("more than one cell finished a token");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_flight || held_valid)
    else $error("accepted request left no trace");
`endif

endmodule
